// ===== sv/mk_pkg.sv =====
package mk_pkg;

  localparam int unsigned DUR_W     = 26;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned PAT_W     = 5;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [DUR_W-1:0] DOT_ON_RST     = DUR_W'(2500000);
  localparam logic [DUR_W-1:0] DASH_ON_RST    = DUR_W'(7500000);
  localparam logic [DUR_W-1:0] SYMBOL_GAP_RST = DUR_W'(2500000);
  localparam logic [DUR_W-1:0] LETTER_GAP_RST = DUR_W'(5000000);
  localparam logic [DUR_W-1:0] WORD_GAP_RST   = DUR_W'(2500000);

  localparam logic [CFG_IDX_W-1:0] CFG_DOT_ON     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_ON    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_GAP = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP   = CFG_IDX_W'(4);

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    CMD_SYMBOLS,
    CMD_SPACE,
    CMD_OTHER
  } cmd_kind_t;

  // pat is left-aligned: the first symbol sits in the top bit, 1 = dash
  typedef struct packed {
    cmd_kind_t        kind;
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pat;
    logic             msg_end;
  } cmd_t;

  typedef struct packed {
    logic [DUR_W-1:0] dot_on;
    logic [DUR_W-1:0] dash_on;
    logic [DUR_W-1:0] symbol_gap;
    logic [DUR_W-1:0] letter_gap;
    logic [DUR_W-1:0] word_gap;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_LOAD,
    BK_ON,
    BK_GAP,
    BK_END
  } bk_state_t;

  // {len, pat} with pat right-aligned
  function automatic logic [LEN_W+PAT_W-1:0] letter_code(input logic [4:0] idx);
    logic [LEN_W+PAT_W-1:0] r;
    begin
      unique case (idx)
        5'd0:  r = {3'd2, 5'h01};
        5'd1:  r = {3'd4, 5'h08};
        5'd2:  r = {3'd4, 5'h0A};
        5'd3:  r = {3'd3, 5'h04};
        5'd4:  r = {3'd1, 5'h00};
        5'd5:  r = {3'd4, 5'h02};
        5'd6:  r = {3'd3, 5'h06};
        5'd7:  r = {3'd4, 5'h00};
        5'd8:  r = {3'd2, 5'h00};
        5'd9:  r = {3'd4, 5'h07};
        5'd10: r = {3'd3, 5'h05};
        5'd11: r = {3'd4, 5'h04};
        5'd12: r = {3'd2, 5'h03};
        5'd13: r = {3'd2, 5'h02};
        5'd14: r = {3'd3, 5'h07};
        5'd15: r = {3'd4, 5'h06};
        5'd16: r = {3'd4, 5'h0D};
        5'd17: r = {3'd3, 5'h02};
        5'd18: r = {3'd3, 5'h00};
        5'd19: r = {3'd1, 5'h01};
        5'd20: r = {3'd3, 5'h01};
        5'd21: r = {3'd4, 5'h01};
        5'd22: r = {3'd3, 5'h03};
        5'd23: r = {3'd4, 5'h09};
        5'd24: r = {3'd4, 5'h0B};
        5'd25: r = {3'd4, 5'h0C};
        default: r = {3'd1, 5'h00};
      endcase
      return r;
    end
  endfunction

  function automatic logic [PAT_W-1:0] digit_pat(input logic [3:0] idx);
    logic [PAT_W-1:0] r;
    begin
      unique case (idx)
        4'd0: r = 5'h1F;
        4'd1: r = 5'h0F;
        4'd2: r = 5'h07;
        4'd3: r = 5'h03;
        4'd4: r = 5'h01;
        4'd5: r = 5'h00;
        4'd6: r = 5'h10;
        4'd7: r = 5'h18;
        4'd8: r = 5'h1C;
        4'd9: r = 5'h1E;
        default: r = 5'h00;
      endcase
      return r;
    end
  endfunction

  function automatic cmd_t classify(input logic [CHAR_W-1:0] c, input logic msg_end);
    cmd_t                   cmd;
    logic [LEN_W+PAT_W-1:0] lc;
    logic [CHAR_W-1:0]      off;
    begin
      cmd.kind    = CMD_OTHER;
      cmd.len     = LEN_W'(1);
      cmd.pat     = '0;
      cmd.msg_end = msg_end;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
        off      = c - CHAR_UPPER_A;
        lc       = letter_code(off[4:0]);
        cmd.kind = CMD_SYMBOLS;
        cmd.len  = lc[LEN_W+PAT_W-1:PAT_W];
        cmd.pat  = lc[PAT_W-1:0] << (LEN_W'(PAT_W) - cmd.len);
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        off      = c - CHAR_ZERO;
        cmd.kind = CMD_SYMBOLS;
        cmd.len  = LEN_W'(PAT_W);
        cmd.pat  = digit_pat(off[3:0]);
      end else if (c == CHAR_SPACE) begin
        cmd.kind = CMD_SPACE;
      end
      return cmd;
    end
  endfunction

endpackage

// ===== sv/mk_front.sv =====
module mk_front import mk_pkg::*; (
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic              in_message_end,
  input  logic              q_full,
  output logic              in_stall,
  output logic              q_push,
  output cmd_t              q_cmd
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_cmd    = classify(in_char_code, in_message_end);

endmodule

// ===== sv/mk_queue.sv =====
module mk_queue import mk_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head_cmd
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/mk_back.sv =====
module mk_back import mk_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_key_level,
  output logic [DUR_W-1:0] out_duration,
  output logic             out_run_last,
  output logic             out_message_done
);

  bk_state_t        state_r, state_nxt;
  logic [PAT_W-1:0] pat_r, pat_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic             msg_r, msg_nxt;

  logic             out_valid_r;
  logic             key_r, last_r, done_r;
  logic [DUR_W-1:0] dur_r;

  logic             out_adv;
  logic             emit;
  logic             seg_level, seg_last, seg_msg;
  logic [DUR_W-1:0] seg_dur;

  // output register is free when empty or being taken this cycle
  assign out_adv = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    pat_nxt   = pat_r;
    left_nxt  = left_r;
    msg_nxt   = msg_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    seg_level = 1'b0;
    seg_dur   = '0;
    seg_last  = 1'b0;
    seg_msg   = msg_r;
    unique case (state_r)
      BK_LOAD: begin
        if (q_valid && out_adv) begin
          q_pop   = 1'b1;
          emit    = 1'b1;
          msg_nxt = q_cmd.msg_end;
          seg_msg = q_cmd.msg_end;
          unique case (q_cmd.kind)
            CMD_SYMBOLS: begin
              seg_level = 1'b1;
              seg_dur   = q_cmd.pat[PAT_W-1] ? cfg.dash_on : cfg.dot_on;
              pat_nxt   = {q_cmd.pat[PAT_W-2:0], 1'b0};
              left_nxt  = q_cmd.len - LEN_W'(1);
              state_nxt = BK_GAP;
            end
            CMD_SPACE: begin
              seg_dur  = cfg.word_gap;
              seg_last = 1'b1;
            end
            default: begin
              seg_last = 1'b1;
            end
          endcase
        end
      end
      BK_ON: begin
        if (out_adv) begin
          emit      = 1'b1;
          seg_level = 1'b1;
          seg_dur   = pat_r[PAT_W-1] ? cfg.dash_on : cfg.dot_on;
          pat_nxt   = {pat_r[PAT_W-2:0], 1'b0};
          left_nxt  = left_r - LEN_W'(1);
          state_nxt = BK_GAP;
        end
      end
      BK_GAP: begin
        if (out_adv) begin
          emit      = 1'b1;
          seg_dur   = cfg.symbol_gap;
          state_nxt = (left_r == '0) ? BK_END : BK_ON;
        end
      end
      BK_END: begin
        if (out_adv) begin
          emit      = 1'b1;
          seg_dur   = cfg.letter_gap;
          seg_last  = 1'b1;
          state_nxt = BK_LOAD;
        end
      end
      default: begin
        state_nxt = BK_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    pat_r  <= pat_nxt;
    left_r <= left_nxt;
    msg_r  <= msg_nxt;
    if (emit) begin
      key_r  <= seg_level;
      dur_r  <= seg_dur;
      last_r <= seg_last;
      done_r <= seg_last && seg_msg;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_level    = key_r;
  assign out_duration     = dur_r;
  assign out_run_last     = last_r;
  assign out_message_done = done_r;

endmodule

// ===== sv/morse_keyer.sv =====
// A taken request is written into the command queue; its first segment is then registered
// in the output register. Throughput: one segment per cycle while not stalled; a letter
// or digit of n symbols gives 2n+1 segments (at most 11), a space or other code gives one.
// The segment engine sets this. A command queue in front of it keeps taking requests
// while the output is stalled, until it is full. Reset: synchronous, active low; timing
// registers return to their defaults, queue and output empty.
module morse_keyer import mk_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic                 in_message_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_key_level,
  output logic [DUR_W-1:0]     out_duration,
  output logic                 out_run_last,
  output logic                 out_message_done,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, head_cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DOT_ON:     cfg_nxt.dot_on     = cfg_data;
        CFG_DASH_ON:    cfg_nxt.dash_on    = cfg_data;
        CFG_SYMBOL_GAP: cfg_nxt.symbol_gap = cfg_data;
        CFG_LETTER_GAP: cfg_nxt.letter_gap = cfg_data;
        CFG_WORD_GAP:   cfg_nxt.word_gap   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_on     <= DOT_ON_RST;
      cfg_r.dash_on    <= DASH_ON_RST;
      cfg_r.symbol_gap <= SYMBOL_GAP_RST;
      cfg_r.letter_gap <= LETTER_GAP_RST;
      cfg_r.word_gap   <= WORD_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mk_front u_front (
    .in_valid       (in_valid),
    .in_char_code   (in_char_code),
    .in_message_end (in_message_end),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  mk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  mk_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_level    (out_key_level),
    .out_duration     (out_duration),
    .out_run_last     (out_run_last),
    .out_message_done (out_message_done)
  );

endmodule

// ===== sv/mk_checker.sv =====
module mk_checker import mk_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_key_level,
  input logic [DUR_W-1:0] out_duration,
  input logic             out_run_last,
  input logic             out_message_done
);

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_done |-> out_run_last)
    else $error("message_done without run_last");

  a_key_down_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_level |-> !out_run_last)
    else $error("key-down segment marked last");

  // a key-down segment is always followed at once by its symbol gap
  a_gap_follows_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_key_level |=> out_valid && !out_key_level)
    else $error("symbol gap missing after key-down segment");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duration)
      && $stable(out_key_level) && $stable(out_run_last))
    else $error("stalled segment changed");

endmodule

bind morse_keyer mk_checker u_mk_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_key_level    (out_key_level),
  .out_duration     (out_duration),
  .out_run_last     (out_run_last),
  .out_message_done (out_message_done)
);

// ===== test/testbench.sv =====
module testbench import mk_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KEY_UP   = 1'b0;
  localparam logic KEY_DOWN = 1'b1;
  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};
  localparam int DIR_N = 22;

  typedef struct packed {
    logic             key_level;
    logic [DUR_W-1:0] duration;
    logic             run_last;
    logic             message_done;
  } segment_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              message_end;
    logic              typed;
    segment_t          seg;
  } char_row_t;

  localparam segment_t NO_SEG = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic in_message_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_key_level;
  logic [DUR_W-1:0] out_duration;
  logic out_run_last;
  logic out_message_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0] cfg_data = '0;

  cfg_t timing;
  segment_t pending_segments[$];
  int error_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // Typed rows are single-segment results that follow directly from reset timing
  char_row_t directed_rows [DIR_N] = '{
    {8'h00, 1'b0, 1'b1, {KEY_UP, DUR_W'(0), 1'b1, 1'b0}},
    {8'hFF, 1'b1, 1'b1, {KEY_UP, DUR_W'(0), 1'b1, 1'b1}},
    {CHAR_SPACE, 1'b0, 1'b1, {KEY_UP, WORD_GAP_RST, 1'b1, 1'b0}},
    {CHAR_SPACE, 1'b1, 1'b1, {KEY_UP, WORD_GAP_RST, 1'b1, 1'b1}},
    {"a", 1'b0, 1'b1, {KEY_UP, DUR_W'(0), 1'b1, 1'b0}},
    {"z", 1'b1, 1'b1, {KEY_UP, DUR_W'(0), 1'b1, 1'b1}},
    {"/", 1'b0, 1'b1, {KEY_UP, DUR_W'(0), 1'b1, 1'b0}},
    {":", 1'b0, 1'b1, {KEY_UP, DUR_W'(0), 1'b1, 1'b0}},
    {"@", 1'b0, 1'b1, {KEY_UP, DUR_W'(0), 1'b1, 1'b0}},
    {"[", 1'b1, 1'b1, {KEY_UP, DUR_W'(0), 1'b1, 1'b1}},
    {8'h80, 1'b0, 1'b1, {KEY_UP, DUR_W'(0), 1'b1, 1'b0}},
    {"A", 1'b0, 1'b0, NO_SEG},
    {"Z", 1'b1, 1'b0, NO_SEG},
    {"E", 1'b0, 1'b0, NO_SEG},
    {"T", 1'b0, 1'b0, NO_SEG},
    {"K", 1'b0, 1'b0, NO_SEG},
    {"W", 1'b1, 1'b0, NO_SEG},
    {"Q", 1'b0, 1'b0, NO_SEG},
    {"H", 1'b0, 1'b0, NO_SEG},
    {"0", 1'b0, 1'b0, NO_SEG},
    {"5", 1'b1, 1'b0, NO_SEG},
    {"9", 1'b0, 1'b0, NO_SEG}
  };

  morse_keyer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_message_end   (in_message_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_level    (out_key_level),
    .out_duration     (out_duration),
    .out_run_last     (out_run_last),
    .out_message_done (out_message_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Dots and dashes per character; empty for anything that is not an upper-case letter or digit
  function automatic string morse_pattern(input logic [CHAR_W-1:0] c);
    case (c)
      "A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
      "E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
      "I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
      "Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
      "U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--";  "Z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
      "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
      "8": return "---.."; "9": return "----.";
      default: return "";
    endcase
  endfunction

  function automatic void predict_keying(input logic [CHAR_W-1:0] c, input logic msg_end);
    string code;
    code = morse_pattern(c);
    if (c == CHAR_SPACE) begin
      pending_segments.push_back({KEY_UP, timing.word_gap, 1'b1, msg_end});
    end else if (code.len() == 0) begin
      pending_segments.push_back({KEY_UP, DUR_W'(0), 1'b1, msg_end});
    end else begin
      for (int k = 0; k < code.len(); k++) begin
        pending_segments.push_back({KEY_DOWN,
                                    (code[k] == "-") ? timing.dash_on : timing.dot_on,
                                    1'b0, 1'b0});
        pending_segments.push_back({KEY_UP, timing.symbol_gap, 1'b0, 1'b0});
      end
      pending_segments.push_back({KEY_UP, timing.letter_gap, 1'b1, msg_end});
    end
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return CHAR_UPPER_A + CHAR_W'($urandom_range(25));
    if (pick < 75) return CHAR_ZERO + CHAR_W'($urandom_range(9));
    if (pick < 85) return CHAR_SPACE;
    return CHAR_W'($urandom_range(255));
  endfunction

  // Hold the request until it is taken; returns at the accepting edge
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic msg_end);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_message_end <= msg_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic [CHAR_W-1:0] c;
    logic              msg_end;
    for (int i = 0; i < count; i++) begin
      c       = random_char();
      msg_end = ($urandom_range(3) == 0);
      send_char(c, msg_end);
      predict_keying(c, msg_end);
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_segments.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DOT_ON:     timing.dot_on     = data;
      CFG_DASH_ON:    timing.dash_on    = data;
      CFG_SYMBOL_GAP: timing.symbol_gap = data;
      CFG_LETTER_GAP: timing.letter_gap = data;
      CFG_WORD_GAP:   timing.word_gap   = data;
      default: ;
    endcase
  endtask

  // Also write every index past the register list; those writes must change nothing
  task automatic load_timing(input logic [DUR_W-1:0] dot, input logic [DUR_W-1:0] dash,
                             input logic [DUR_W-1:0] sym, input logic [DUR_W-1:0] letter,
                             input logic [DUR_W-1:0] word);
    write_reg(CFG_WORD_GAP, word);
    write_reg(CFG_DOT_ON, dot);
    write_reg(CFG_LETTER_GAP, letter);
    write_reg(CFG_DASH_ON, dash);
    write_reg(CFG_SYMBOL_GAP, sym);
    for (int i = int'(CFG_WORD_GAP) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), DUR_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : segment_check
    segment_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_segments.size() == 0) begin
          $error("unexpected segment: key_level %0d duration %0d run_last %0d done %0d",
                 out_key_level, out_duration, out_run_last, out_message_done);
          error_count++;
        end else begin
          want = pending_segments.pop_front();
          if (out_key_level !== want.key_level) begin
            $error("key_level: expected %0d, got %0d", want.key_level, out_key_level);
            error_count++;
          end
          if (out_duration !== want.duration) begin
            $error("duration: expected %0d, got %0d", want.duration, out_duration);
            error_count++;
          end
          if (out_run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_run_last);
            error_count++;
          end
          if (out_message_done !== want.message_done) begin
            $error("message_done: expected %0d, got %0d", want.message_done,
                   out_message_done);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  initial begin
    timing.dot_on     = DOT_ON_RST;
    timing.dash_on    = DASH_ON_RST;
    timing.symbol_gap = SYMBOL_GAP_RST;
    timing.letter_gap = LETTER_GAP_RST;
    timing.word_gap   = WORD_GAP_RST;
    sender_idle_pct    = 31;
    receiver_stall_pct = 51;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_char(directed_rows[i].char_code, directed_rows[i].message_end);
      if (directed_rows[i].typed)
        pending_segments.push_back(directed_rows[i].seg);
      else
        predict_keying(directed_rows[i].char_code, directed_rows[i].message_end);
    end
    in_valid <= 1'b0;
    // Pause the sender until the output has fully caught up
    wait_drained();
    send_random(16);
    wait_drained();

    load_timing(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX);
    send_random(18);
    wait_drained();

    sender_idle_pct    = 51;
    receiver_stall_pct = 31;
    load_timing('0, '0, '0, '0, '0);
    send_random(18);
    wait_drained();

    load_timing(DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom),
                DUR_W'($urandom), DUR_W'($urandom));
    send_random(18);
    wait_drained();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    load_timing(DUR_W'($urandom_range(1000)), DUR_W'($urandom_range(1000)),
                DUR_W'($urandom_range(1000)), DUR_W'($urandom_range(1000)),
                DUR_W'($urandom_range(1000)));
    send_random(18);
    wait_drained();

    // Catch any stray segment after the last expected one
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
